FILE: src/ardk_pkg.sv
// shared types and constants for the arcsine ard kernel evaluator
// used by ardk_ctrl, ardk_dpath and the top level; no dependencies
package ardk_pkg;

    localparam int MAX_DIMS     = 1024;
    localparam int CNT_W        = $clog2(MAX_DIMS + 1);
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 63;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 6;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL,
        OP_NINIT,
        OP_NORM,
        OP_PAR,
        OP_PROD,
        OP_SQRT,
        OP_DINIT,
        OP_DIV,
        OP_RATIO,
        OP_COSP,
        OP_CINIT,
        OP_CORD,
        OP_SC1,
        OP_SC2,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [STEP_W-1:0]  step;
        logic               acc;
        logic               load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic norm_done;
        logic out_free;
    } t_status;

    // arctan(2^-i) in q24 radians
    function automatic logic [23:0] atan_q24(input logic [4:0] idx);
        logic [23:0] v;
        unique case (idx)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/ardk_ctrl.sv
// controller state machine for the arcsine ard kernel evaluator
// depends on ardk_pkg; drives ardk_dpath through t_cmd
module ardk_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ardk_pkg::t_status i_status,
    output ardk_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_ACC, S_NINIT, S_NORM, S_PAR, S_PROD, S_SQRT,
        S_DINIT, S_DIV, S_RATIO, S_COSP, S_CSQRT, S_CINIT, S_CORD,
        S_SC1, S_SC2, S_OUT
    } t_state;

    t_state                      r_state, n_state;
    logic [ardk_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_pend, n_pend;
    logic                        w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_pend  = r_pend;
        o_cmd.op   = ardk_pkg::OP_NONE;
        o_cmd.step = r_step;
        o_cmd.acc  = 1'b0;
        o_cmd.load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // products of the previous element are summed here
                o_cmd.acc  = r_pend;
                o_cmd.load = w_acc;
                n_pend     = 1'b0;
                if (w_acc) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = ardk_pkg::OP_MUL;
                if (i_status.last) begin
                    n_state = S_ACC;
                end else begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_NINIT;
            end
            S_NINIT: begin
                o_cmd.op = ardk_pkg::OP_NINIT;
                n_state  = S_NORM;
            end
            S_NORM: begin
                o_cmd.op = ardk_pkg::OP_NORM;
                if (i_status.norm_done) n_state = S_PAR;
            end
            S_PAR: begin
                o_cmd.op = ardk_pkg::OP_PAR;
                n_state  = S_PROD;
            end
            S_PROD: begin
                o_cmd.op = ardk_pkg::OP_PROD;
                n_step   = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = ardk_pkg::OP_SQRT;
                n_step   = r_step + 1'b1;
                if (r_step == ardk_pkg::STEP_W'(ardk_pkg::SQRT_STEPS - 1)) n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = ardk_pkg::OP_DINIT;
                n_step   = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = ardk_pkg::OP_DIV;
                n_step   = r_step + 1'b1;
                if (r_step == ardk_pkg::STEP_W'(ardk_pkg::DIV_STEPS - 1)) n_state = S_RATIO;
            end
            S_RATIO: begin
                o_cmd.op = ardk_pkg::OP_RATIO;
                n_state  = S_COSP;
            end
            S_COSP: begin
                o_cmd.op = ardk_pkg::OP_COSP;
                n_step   = '0;
                n_state  = S_CSQRT;
            end
            S_CSQRT: begin
                o_cmd.op = ardk_pkg::OP_SQRT;
                n_step   = r_step + 1'b1;
                if (r_step == ardk_pkg::STEP_W'(ardk_pkg::SQRT_STEPS - 1)) n_state = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.op = ardk_pkg::OP_CINIT;
                n_step   = '0;
                n_state  = S_CORD;
            end
            S_CORD: begin
                o_cmd.op = ardk_pkg::OP_CORD;
                n_step   = r_step + 1'b1;
                if (r_step == ardk_pkg::STEP_W'(ardk_pkg::CORDIC_STEPS - 1)) n_state = S_SC1;
            end
            S_SC1: begin
                o_cmd.op = ardk_pkg::OP_SC1;
                n_state  = S_SC2;
            end
            S_SC2: begin
                o_cmd.op = ardk_pkg::OP_SC2;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = ardk_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pend  <= n_pend;
        end
    end

endmodule

FILE: src/ardk_dpath.sv
// datapath of the arcsine ard kernel evaluator: sums, normalize, sqrt,
// divide, cordic and output scaling; depends on ardk_pkg
module ardk_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ardk_pkg::t_cmd       i_cmd,
    output ardk_pkg::t_status    o_status,
    input  logic [15:0]          i_bias,
    input  logic [15:0]          i_scale,
    input  logic signed [15:0]   i_sample_left,
    input  logic signed [15:0]   i_sample_right,
    input  logic [15:0]          i_dim_weight,
    input  logic signed [15:0]   i_gating,
    input  logic                 i_last_element,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [26:0]   o_kernel_value
);

    logic signed [15:0] r_a, r_b, r_g;
    logic [15:0]        r_w;
    logic               r_last;
    logic signed [31:0] r_pab, r_paa, r_pbb;
    logic signed [63:0] r_cross, r_lself, r_rself;
    logic               r_start;
    logic [ardk_pkg::CNT_W-1:0] r_cnt;
    logic [63:0]        r_nx, r_ny;
    logic [5:0]         r_sx, r_sy;
    logic [63:0]        r_sq_n, r_sq_res;
    logic [31:0]        r_dd, r_rem;
    logic [62:0]        r_num;
    logic [30:0]        r_rmag;
    logic               r_rneg;
    logic signed [33:0] r_cx, r_cy;
    logic signed [27:0] r_cz;
    logic [42:0]        r_m1;
    logic [58:0]        r_m2;
    logic               r_pneg;
    logic               r_ovalid;
    logic signed [26:0] r_odata;

    logic signed [48:0] w_tab, w_taa, w_tbb;
    logic [63:0]        w_seed;
    logic [ardk_pkg::CNT_W-1:0] w_cnt_base;
    logic signed [63:0] w_bc, w_bl, w_br;
    logic               w_nxbig, w_nybig;
    logic [6:0]         w_hsum;
    logic [5:0]         w_h;
    logic [61:0]        w_xy, w_rsq;
    logic [63:0]        w_bit, w_trial;
    logic [63:0]        w_mag, w_sh;
    logic [32:0]        w_cq;
    logic [32:0]        w_rs;
    logic               w_qbit;
    logic signed [33:0] w_dx, w_dy;
    logic signed [27:0] w_atan;
    logic [27:0]        w_az;
    logic [15:0]        w_ag;
    logic [59:0]        w_rnd;
    logic [26:0]        w_p;
    logic               w_out_free;

    assign w_tab = r_pab * $signed({1'b0, r_w});
    assign w_taa = r_paa * $signed({1'b0, r_w});
    assign w_tbb = r_pbb * $signed({1'b0, r_w});
    assign w_seed     = {24'd0, i_bias, 24'd0};
    assign w_cnt_base = r_start ? '0 : r_cnt;
    assign w_bc = r_start ? $signed(w_seed) : r_cross;
    assign w_bl = r_start ? $signed(w_seed) : r_lself;
    assign w_br = r_start ? $signed(w_seed) : r_rself;

    assign w_nxbig = |r_nx[63:31];
    assign w_nybig = |r_ny[63:31];
    assign w_hsum  = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_h     = w_hsum[6:1];

    assign w_xy  = r_nx[30:0] * r_ny[30:0];
    assign w_rsq = r_rmag * r_rmag;

    assign w_bit   = 64'd1 << (7'd62 - {i_cmd.step, 1'b0});
    assign w_trial = r_sq_res + w_bit;

    assign w_mag = r_cross[63] ? 64'(-r_cross) : 64'(r_cross);
    assign w_sh  = w_mag >> w_h;
    assign w_cq  = (w_sh > 64'h1_0000_0000) ? 33'h1_0000_0000 : w_sh[32:0];

    assign w_rs   = {r_rem, r_num[62]};
    assign w_qbit = (w_rs >= {1'b0, r_dd});

    assign w_dx   = r_cy >>> i_cmd.step[4:0];
    assign w_dy   = r_cx >>> i_cmd.step[4:0];
    assign w_atan = $signed({4'd0, ardk_pkg::atan_q24(i_cmd.step[4:0])});

    assign w_az = r_cz[27] ? 28'(-r_cz) : 28'(r_cz);
    assign w_ag = r_g[15] ? 16'(-r_g) : 16'(r_g);

    // round half away from zero on the magnitude, then cap
    assign w_rnd = ({1'b0, r_m2} + 60'h2000_0000) >> 30;
    assign w_p   = (w_rnd > 60'h400_0000) ? 27'h400_0000 : w_rnd[26:0];

    assign w_out_free = !r_ovalid || i_out_ready;

    assign o_status.last      = r_last;
    assign o_status.norm_done = !w_nxbig && !w_nybig;
    assign o_status.out_free  = w_out_free;

    assign o_out_valid    = r_ovalid;
    assign o_kernel_value = r_odata;

    // control: vector start, element count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 1'b1;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_start <= r_last;
                if (w_cnt_base < ardk_pkg::CNT_W'(ardk_pkg::MAX_DIMS)) begin
                    r_cnt <= w_cnt_base + 1'b1;
                end else begin
                    r_cnt <= w_cnt_base;
                end
            end
            if (i_cmd.op == ardk_pkg::OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_sample_left;
            r_b    <= i_sample_right;
            r_w    <= i_dim_weight;
            r_g    <= i_gating;
            r_last <= i_last_element;
        end
        if (i_cmd.acc) begin
            if (w_cnt_base < ardk_pkg::CNT_W'(ardk_pkg::MAX_DIMS)) begin
                r_cross <= w_bc + {{15{w_tab[48]}}, w_tab};
                r_lself <= w_bl + {{15{w_taa[48]}}, w_taa};
                r_rself <= w_br + {{15{w_tbb[48]}}, w_tbb};
            end else begin
                r_cross <= w_bc;
                r_lself <= w_bl;
                r_rself <= w_br;
            end
        end
        unique case (i_cmd.op)
            ardk_pkg::OP_MUL: begin
                r_pab <= r_a * r_b;
                r_paa <= r_a * r_a;
                r_pbb <= r_b * r_b;
            end
            ardk_pkg::OP_NINIT: begin
                r_nx <= 64'(r_lself) + 64'h1_0000_0000;
                r_ny <= 64'(r_rself) + 64'h1_0000_0000;
                r_sx <= '0;
                r_sy <= '0;
            end
            ardk_pkg::OP_NORM: begin
                if (w_nxbig) begin
                    r_nx <= r_nx >> 1;
                    r_sx <= r_sx + 1'b1;
                end
                if (w_nybig) begin
                    r_ny <= r_ny >> 1;
                    r_sy <= r_sy + 1'b1;
                end
            end
            ardk_pkg::OP_PAR: begin
                if (r_sx[0] ^ r_sy[0]) begin
                    r_nx <= r_nx >> 1;
                    r_sx <= r_sx + 1'b1;
                end
            end
            ardk_pkg::OP_PROD: begin
                r_sq_n   <= {2'b00, w_xy};
                r_sq_res <= '0;
            end
            ardk_pkg::OP_SQRT: begin
                if (r_sq_n >= w_trial) begin
                    r_sq_n   <= r_sq_n - w_trial;
                    r_sq_res <= (r_sq_res >> 1) + w_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
            end
            ardk_pkg::OP_DINIT: begin
                r_dd  <= (r_sq_res == 64'd0) ? 32'd1 : r_sq_res[31:0];
                r_num <= {w_cq, 30'd0};
                r_rem <= '0;
            end
            ardk_pkg::OP_DIV: begin
                r_rem <= w_qbit ? 32'(w_rs - {1'b0, r_dd}) : w_rs[31:0];
                r_num <= {r_num[61:0], w_qbit};
            end
            ardk_pkg::OP_RATIO: begin
                r_rmag <= (r_num > 63'h4000_0000) ? 31'h4000_0000 : r_num[30:0];
                r_rneg <= r_cross[63];
            end
            ardk_pkg::OP_COSP: begin
                r_sq_n   <= (64'd1 << 60) - {2'b00, w_rsq};
                r_sq_res <= '0;
            end
            ardk_pkg::OP_CINIT: begin
                r_cx <= $signed({3'd0, r_sq_res[30:0]});
                r_cy <= r_rneg ? -$signed({3'd0, r_rmag}) : $signed({3'd0, r_rmag});
                r_cz <= '0;
            end
            ardk_pkg::OP_CORD: begin
                // a step with y at zero leaves the vector alone
                if (!r_cy[33] && (r_cy != 34'sd0)) begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_cz <= r_cz + w_atan;
                end else if (r_cy[33]) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_cz <= r_cz - w_atan;
                end
            end
            ardk_pkg::OP_SC1: begin
                r_m1   <= i_scale * w_az[26:0];
                r_pneg <= r_cz[27] ^ r_g[15];
            end
            ardk_pkg::OP_SC2: begin
                r_m2 <= r_m1 * w_ag;
            end
            ardk_pkg::OP_OUT: begin
                if (r_pneg) begin
                    r_odata <= -$signed(w_p);
                end else if (w_p == 27'h400_0000) begin
                    r_odata <= 27'sh3FF_FFFF;
                end else begin
                    r_odata <= $signed(w_p);
                end
            end
            default: ;
        endcase
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == ardk_pkg::OP_DIV |-> r_dd != 32'd0)
        else $error("divisor is zero during divide");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == ardk_pkg::OP_PROD |-> (!w_nxbig && !w_nybig && !r_sx[0] ^ r_sy[0]
            || !w_nxbig && !w_nybig && (r_sx[0] == r_sy[0])))
        else $error("normalized operands out of range or odd shift");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == ardk_pkg::OP_OUT |-> w_out_free)
        else $error("output overwritten before transfer");

endmodule

FILE: src/arcsine_ard_kernel_eval_core.sv
// top level of the arcsine ard kernel evaluator: stream ports, apb registers
// depends on ardk_pkg, ardk_ctrl and ardk_dpath
//
// Takes one element pair per transfer and returns one kernel value after the
// transfer marked tlast. A non-last element passes through a multiply state, and
// its accumulate overlaps the next intake. The last element goes through a normalize
// loop, two 32-step square root passes on a shared radix-2 unit, a 63-step restoring
// divider, 24 cordic steps and the scaling multiplies; no new element is taken
// meanwhile. The finished value sits in an output register, so intake resumes
// while it waits for the downstream side; a later result that finds that register
// still full waits for it, adding cycles.
module arcsine_ard_kernel_eval_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_left[15:0], sample_right[31:16], dim_weight[47:32], gating[63:48]
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kernel_value[26:0], zero fill [31:27]
    output logic [31:0] m_axis_tdata
);

    logic [15:0]        r_bias, r_scale;
    ardk_pkg::t_cmd     w_cmd;
    ardk_pkg::t_status  w_status;
    logic signed [26:0] w_kv;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias  <= 16'd512;
            r_scale <= 16'd256;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_scale <= pwdata[15:0];
            end else begin
                r_bias <= pwdata[15:0];
            end
        end
    end

    assign prdata = {16'd0, paddr[2] ? r_scale : r_bias};

    ardk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ardk_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_bias         (r_bias),
        .i_scale        (r_scale),
        .i_sample_left  (s_axis_tdata[15:0]),
        .i_sample_right (s_axis_tdata[31:16]),
        .i_dim_weight   (s_axis_tdata[47:32]),
        .i_gating       (s_axis_tdata[63:48]),
        .i_last_element (s_axis_tlast),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_kernel_value (w_kv)
    );

    assign m_axis_tdata = {5'd0, w_kv};

endmodule

FILE: test/arcsine_ard_kernel_eval_core_chk.sv
// checker for the arcsine ard kernel evaluator: watches apb writes and both streams,
// predicts each kernel value and compares it with the output transfer; no dependencies
module arcsine_ard_kernel_eval_core_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int          MAX_ELEMS = 1024;
    localparam logic [2:0]  ADDR_BIAS = 3'd0;
    localparam logic [2:0]  ADDR_SCALE = 3'd4;
    localparam longint      KV_MAX = 64'sd67108863;
    localparam longint      KV_MIN = -64'sd67108864;

    localparam longint ATAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic [15:0] bias_q88;
    logic [15:0] scale_q88;
    longint      cross_acc;
    longint      left_acc;
    longint      right_acc;
    bit          vec_start;
    int          elem_cnt;
    logic [26:0] kernel_q [$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bv;
        res = 0;
        bv = 64'h1 << 62;
        while (bv > n) bv = bv >> 2;
        while (bv != 0) begin
            if (n >= res + bv) begin
                n = n - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    // normalized correlation in q1.30
    function automatic longint corr_q30(input longint cs, input longint ls, input longint rs);
        longint unsigned xs, ys, d, mag, cq, q;
        int sx, sy, h;
        xs = longint'(ls) + (64'h1 << 32);
        ys = longint'(rs) + (64'h1 << 32);
        sx = 0;
        sy = 0;
        while ((xs >> sx) >= (64'h1 << 31)) sx++;
        while ((ys >> sy) >= (64'h1 << 31)) sy++;
        if ((sx + sy) % 2 == 1) sx++;
        h = (sx + sy) / 2;
        d = int_sqrt((xs >> sx) * (ys >> sy));
        if (d == 0) d = 1;
        mag = (cs < 0) ? -cs : cs;
        cq = mag >> h;
        if (cq > (64'h1 << 32)) cq = 64'h1 << 32;
        q = (cq << 30) / d;
        if (q > (64'h1 << 30)) q = 64'h1 << 30;
        return (cs < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint arcsin_q24(input longint r);
        longint unsigned rr;
        longint x, y, z, dx, dy;
        rr = (r < 0) ? -r : r;
        x = int_sqrt((64'h1 << 60) - rr * rr);
        y = r;
        z = 0;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + ATAN_Q24[i];
            end else if (y < 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_Q24[i];
            end
        end
        return z;
    endfunction

    function automatic logic [26:0] kernel_value(input longint g);
        longint z, v;
        longint unsigned az, ag, p;
        if (g == 0) return '0;
        z = arcsin_q24(corr_q30(cross_acc, left_acc, right_acc));
        az = (z < 0) ? -z : z;
        ag = (g < 0) ? -g : g;
        p = longint'(scale_q88) * az * ag;
        p = (p + (64'h1 << 29)) >> 30;
        if (p > (64'h1 << 26)) p = 64'h1 << 26;
        v = ((z < 0) != (g < 0)) ? -longint'(p) : longint'(p);
        if (v > KV_MAX) v = KV_MAX;
        if (v < KV_MIN) v = KV_MIN;
        return v[26:0];
    endfunction

    always @(posedge i_clk) begin
        longint a, b, w, g, seed;
        logic [26:0] exp_kv;
        if (!i_rst_n) begin
            bias_q88  <= 16'd512;
            scale_q88 <= 16'd256;
            vec_start = 1'b1;
            elem_cnt  = 0;
            cross_acc = 0;
            left_acc  = 0;
            right_acc = 0;
            kernel_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_BIAS) bias_q88 <= pwdata[15:0];
                if (paddr == ADDR_SCALE) scale_q88 <= pwdata[15:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                a = $signed(s_axis_tdata[15:0]);
                b = $signed(s_axis_tdata[31:16]);
                w = longint'({48'd0, s_axis_tdata[47:32]});
                g = $signed(s_axis_tdata[63:48]);
                if (vec_start) begin
                    seed = longint'({48'd0, bias_q88}) << 24;
                    cross_acc = seed;
                    left_acc  = seed;
                    right_acc = seed;
                    elem_cnt  = 0;
                    vec_start = 1'b0;
                end
                // elements beyond the dimension limit are dropped
                if (elem_cnt < MAX_ELEMS) begin
                    cross_acc += a * b * w;
                    left_acc  += a * a * w;
                    right_acc += b * b * w;
                    elem_cnt++;
                end
                if (s_axis_tlast) begin
                    vec_start = 1'b1;
                    kernel_q.push_back(kernel_value(g));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (kernel_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("kernel transfer with none expected: %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_kv = kernel_q.pop_front();
                    if (m_axis_tdata !== {5'd0, exp_kv}) begin
                        if (o_fail_count < 10)
                            $display("kernel_value mismatch: expected %h got %h",
                                     {5'd0, exp_kv}, m_axis_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= kernel_q.size();
        end
    end

endmodule

FILE: test/arcsine_ard_kernel_eval_core_tb.sv
// testbench top for arcsine_ard_kernel_eval_core: clock, reset, apb writes and
// stream stimulus; depends on the block and arcsine_ard_kernel_eval_core_chk
module arcsine_ard_kernel_eval_core_tb;

    localparam logic [2:0] ADDR_BIAS  = 3'd0;
    localparam logic [2:0] ADDR_SCALE = 3'd4;
    localparam int         STALL_LIMIT = 20000;
    localparam int         N_PHASES = 8;
    localparam int         HOLD_LEN = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    int          fail_count;
    int          pending;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          phase_idx = -1;
    int          hold_cycles = 0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;
    int          elems_sent = 0;

    arcsine_ard_kernel_eval_core i_dut (.*);

    arcsine_ard_kernel_eval_core_chk i_chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // downstream side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (phase_idx == 4 && !hold_done) begin
            hold_done     <= 1'b1;
            hold_cycles   <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("arcsine_ard_kernel_eval_core regression: fail");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_elem(input logic [15:0] left, input logic [15:0] right,
                             input logic [15:0] wt, input logic [15:0] gate,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {gate, wt, right, left};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        elems_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(3))
            0: return 16'hffff;
            1: return 16'($urandom_range(511));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gating();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'h4000;
            2: return 16'hc000;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic send_vector(input int len);
        for (int k = 0; k < len; k++)
            send_elem(pick_sample(), pick_sample(), pick_weight(), pick_gating(), k == len - 1);
    endtask

    initial begin
        int len;
        int quota;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero gating, single and short vectors
        send_elem(16'h7fff, 16'h7fff, 16'hffff, 16'h4000, 1'b1);
        send_elem(16'h8000, 16'h7fff, 16'hffff, 16'hc000, 1'b1);
        send_elem(16'h8000, 16'h8000, 16'hffff, 16'h4000, 1'b1);
        send_elem(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_elem(16'h1000, 16'hf000, 16'h0100, 16'h7fff, 1'b1);
        send_elem(16'h1000, 16'h1000, 16'h0100, 16'h8000, 1'b1);
        send_elem(16'h1234, 16'h0800, 16'h0200, 16'h0000, 1'b0);
        send_elem(16'hedcc, 16'h0800, 16'h0080, 16'h0000, 1'b0);
        send_elem(16'h0400, 16'hfc00, 16'h0100, 16'h0000, 1'b1);
        send_elem(16'h0001, 16'hffff, 16'h0001, 16'h0001, 1'b1);
        send_elem(16'h2000, 16'h2000, 16'h0100, 16'hffff, 1'b1);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            phase_idx = ph;
            case (ph)
                0: begin reg_write(ADDR_BIAS, 32'd0);     reg_write(ADDR_SCALE, 32'hffff); end
                1: begin reg_write(ADDR_BIAS, 32'hffff);  reg_write(ADDR_SCALE, 32'd0);    end
                2: begin reg_write(ADDR_BIAS, 32'd512);   reg_write(ADDR_SCALE, 32'd256);  end
                default: begin
                    reg_write(ADDR_BIAS, $urandom_range(65535));
                    reg_write(ADDR_SCALE, $urandom_range(65535));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            quota = elems_sent + 115;
            // one vector at or past the dimension limit in the first phase
            if (ph == 0) send_vector(1024 + $urandom_range(6));
            while (elems_sent < quota) begin
                case ($urandom_range(9))
                    0, 1: len = 1;
                    2, 3, 4, 5: len = $urandom_range(4, 2);
                    default: len = $urandom_range(20, 5);
                endcase
                send_vector(len);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("arcsine_ard_kernel_eval_core regression: pass");
        else
            $display("arcsine_ard_kernel_eval_core regression: fail");
        $finish;
    end

endmodule
